// File: src/hmd_pkg.sv
package hmd_pkg;

  localparam int ROWS = 8;
  localparam int COLS = 32;

  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int IDX_W  = $clog2(COLS + 1);
  localparam int FILL_W = $clog2(ROWS + 1);
  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int VAL_W  = 16;
  localparam int NORM_W = 16;
  localparam int DIFF_W = 17;
  localparam int NUM_W  = 25;
  localparam int SQ_W   = 33;
  localparam int ACC_W  = 40;
  localparam int ROOT_W = 20;
  localparam int DIST_W = 19;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [ACC_W-1:0]  ACC_MAX  = '1;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_PLAIN = 2'd1;
  localparam logic [1:0] FUNC_NORM  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctl_t;

endpackage

// File: src/hmd_if.sv
interface hmd_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic signed [hmd_pkg::VAL_W-1:0]  value;
  logic [hmd_pkg::NORM_W-1:0]        norm;
  logic                              last;

  modport source (output valid, func, value, norm, last, input ready);
  modport sink   (input valid, func, value, norm, last, output ready);
endinterface

interface hmd_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [hmd_pkg::DIST_W-1:0]  distance;
  logic                        history_full;

  modport source (output valid, distance, history_full, input ready);
  modport sink   (input valid, distance, history_full, output ready);
endinterface

// File: src/hmd_cell.sv
module hmd_cell (
  input  logic                      clk,
  input  hmd_pkg::cell_ctl_t        ctl,
  input  logic [hmd_pkg::ACC_W-1:0] acc_in,
  input  logic [hmd_pkg::SQ_W-1:0]  sq,
  output logic [hmd_pkg::ACC_W-1:0] acc
);
  import hmd_pkg::*;

  logic [ACC_W:0] sum;

  assign sum = {1'b0, acc_in} + (ACC_W + 1)'(sq);

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.shift) begin
      acc <= sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    end
  end
endmodule

// File: src/hmd_div.sv
module hmd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hmd_pkg::NUM_W-1:0]  num,
  input  logic [hmd_pkg::NORM_W-1:0] den,
  output logic                       done,
  output logic [hmd_pkg::NUM_W-1:0]  quo
);
  import hmd_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NORM_W:0]    rem;
  logic [NORM_W+1:0]  rem_sh;
  logic [NORM_W-1:0]  den_r;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  assign rem_sh = {rem, quo[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        quo   <= num;
        rem   <= '0;
        den_r <= den;
        cnt   <= CNT_W'(NUM_W);
      end else if (busy) begin
        // restoring step: numerator bits shift out while quotient bits shift in
        if (rem_sh >= (NORM_W + 2)'(den_r)) begin
          rem <= (NORM_W + 1)'(rem_sh - (NORM_W + 2)'(den_r));
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[NORM_W:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: src/hmd_sqrt.sv
module hmd_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hmd_pkg::ACC_W-1:0]  x,
  output logic                       done,
  output logic [hmd_pkg::ROOT_W-1:0] root
);
  import hmd_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 3;

  logic [ACC_W-1:0]   x_sh;
  logic [ROOT_W:0]    rem;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  assign rem_sh = {rem, x_sh[ACC_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        x_sh <= x;
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        // two radicand bits per step, one root bit out
        if (rem_sh >= trial) begin
          rem  <= (ROOT_W + 1)'(rem_sh - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= (ROOT_W + 1)'(rem_sh);
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        x_sh <= {x_sh[ACC_W-3:0], 2'b00};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: src/history_min_l2_distance_unit.sv
// History minimum L2 distance unit.
// req channel: one vector element per beat (func, value, norm, last).
//   func add stores the element into the ring row being filled; func plain or
//   normalized compares it with every stored row; func 3 beats are dropped.
// rsp channel: one beat per query vector, on its last element, giving the
//   smallest truncated Euclidean distance (Q.8 if normalized, integer if plain)
//   and history_full; before all rows are written, distance 0, history_full 0.
// Row sums live in a ring of cells; the ring rotates once per row, feeding
// the cell at its head from the squared difference of that row.
// Steps per beat: add and dropped beats are taken in S_IDLE alone. A plain
//   query element goes through store read, difference, square and accumulate
//   for each row, a normalized one also through the shared serial divider.
//   A query element past the last column skips the rows.
//   The last query element adds a bit-serial square root per row, then loads
//   the output register.
// One beat is worked on at a time; req is ready only between beats.
// A result waits in the output register while rsp stalls; the next req beat is
//   still taken, and only a second result has to wait for the first to leave.
// Reset (rst, synchronous) empties the history and clears the row sums; the
// store contents are left as they are and count only once rewritten.
module history_min_l2_distance_unit (
  input logic      clk,
  input logic      rst,
  hmd_req_if.sink   req,
  hmd_rsp_if.source rsp
);
  import hmd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DIFF, S_DIV, S_SQ, S_ACC, S_END, S_RT_GO, S_RT_WAIT, S_EMIT
  } state_t;

  state_t state;

  logic [VAL_W-1:0]        mem [DEPTH];
  logic [VAL_W-1:0]        mem_q;

  logic [1:0]              func_r;
  logic signed [VAL_W-1:0] value_r;
  logic [NORM_W-1:0]       norm_r;
  logic                    last_r;

  logic [IDX_W-1:0]        idx;
  logic [ROW_W-1:0]        write_row;
  logic [FILL_W-1:0]       rows_filled;
  logic [ROW_W-1:0]        row_cnt;

  logic signed [DIFF_W-1:0]   d_r;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          d_mag;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]            sq_r;
  logic [SQ_W-1:0]            sq_in;
  logic [DIST_W-1:0]          best;

  logic                     div_start, div_done;
  logic [NUM_W-1:0]         div_quo;
  logic signed [DIFF_W-1:0] q_sat;
  logic                     rt_start, rt_done;
  logic [ROOT_W-1:0]        rt_root;

  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic                     accept, in_range;
  cell_ctl_t                ctl;
  logic [ACC_W-1:0]         acc [ROWS];

  logic                     rsp_valid;
  logic [DIST_W-1:0]        rsp_distance;
  logic                     rsp_full;

  assign accept   = req.valid && req.ready;
  assign in_range = idx < IDX_W'(COLS);
  assign wr_addr  = ADDR_W'(ADDR_W'(write_row) * ADDR_W'(COLS) + ADDR_W'(idx));
  assign rd_addr  = ADDR_W'(ADDR_W'(row_cnt) * ADDR_W'(COLS) + ADDR_W'(idx));

  assign req.ready = (state == S_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.distance     = rsp_distance;
  assign rsp.history_full = rsp_full;

  assign diff  = DIFF_W'(value_r) - DIFF_W'($signed(mem_q));
  // divider loads on the same edge that registers the difference
  assign d_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign prod  = d_r * d_r;

  // signed quotient, saturated to 17 bits; zero norm sends a nonzero difference to its sign's limit
  always_comb begin
    if (norm_r == '0) begin
      if (d_r == '0) begin
        q_sat = '0;
      end else if (d_r[DIFF_W-1]) begin
        q_sat = {1'b1, {(DIFF_W-1){1'b0}}};
      end else begin
        q_sat = {1'b0, {(DIFF_W-1){1'b1}}};
      end
    end else if (d_r[DIFF_W-1]) begin
      if (div_quo > NUM_W'(65536)) begin
        q_sat = {1'b1, {(DIFF_W-1){1'b0}}};
      end else begin
        q_sat = DIFF_W'(-div_quo);
      end
    end else begin
      if (div_quo > NUM_W'(65535)) begin
        q_sat = {1'b0, {(DIFF_W-1){1'b1}}};
      end else begin
        q_sat = DIFF_W'(div_quo);
      end
    end
  end

  assign div_start = (state == S_DIFF) && (func_r == FUNC_NORM);
  assign rt_start  = (state == S_RT_GO);
  assign sq_in     = (state == S_ACC) ? sq_r : '0;

  always_comb begin
    ctl.shift = (state == S_ACC) || ((state == S_RT_WAIT) && rt_done);
    ctl.clr   = rst || (state == S_EMIT) ||
                (accept && req.func == FUNC_ADD && req.last);
  end

  hmd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({d_mag, 8'h00}),
    .den   (norm_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  hmd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (rt_start),
    .x     (acc[ROWS-1]),
    .done  (rt_done),
    .root  (rt_root)
  );

  for (genvar i = 0; i < ROWS; i++) begin : g_cell
    hmd_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .acc_in ((i == 0) ? acc[ROWS-1] : acc[(i == 0) ? 0 : i-1]),
      .sq     ((i == 0) ? sq_in : {SQ_W{1'b0}}),
      .acc    (acc[i])
    );
  end

  always_ff @(posedge clk) begin
    if (accept && req.func == FUNC_ADD && in_range) begin
      mem[wr_addr] <= req.value;
    end
    if (state == S_RD) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      write_row   <= '0;
      rows_filled <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != S_EMIT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && req.func != FUNC_NONE) begin
            func_r  <= req.func;
            value_r <= req.value;
            norm_r  <= req.norm;
            last_r  <= req.last;
            if (req.func == FUNC_ADD) begin
              if (req.last) begin
                idx <= '0;
                if (rows_filled < FILL_W'(ROWS)) begin
                  rows_filled <= rows_filled + 1'b1;
                end
                write_row <= (write_row == ROW_W'(ROWS - 1)) ? '0 : write_row + 1'b1;
              end else if (in_range) begin
                idx <= idx + 1'b1;
              end
            end else if (in_range) begin
              row_cnt <= ROW_W'(ROWS - 1);
              state   <= S_RD;
            end else begin
              state <= S_END;
            end
          end
        end
        S_RD: state <= S_DIFF;
        S_DIFF: begin
          d_r   <= diff;
          state <= (func_r == FUNC_NORM) ? S_DIV : S_SQ;
        end
        S_DIV: begin
          if (div_done) begin
            d_r   <= q_sat;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq_r  <= SQ_W'(prod);
          state <= S_ACC;
        end
        S_ACC: begin
          if (row_cnt == '0) begin
            idx   <= idx + 1'b1;
            state <= S_END;
          end else begin
            row_cnt <= row_cnt - 1'b1;
            state   <= S_RD;
          end
        end
        S_END: begin
          if (last_r) begin
            idx     <= '0;
            row_cnt <= ROW_W'(ROWS - 1);
            best    <= DIST_MAX;
            state   <= S_RT_GO;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RT_GO: state <= S_RT_WAIT;
        S_RT_WAIT: begin
          if (rt_done) begin
            if (rt_root < ROOT_W'(best)) begin
              best <= DIST_W'(rt_root);
            end
            if (row_cnt == '0) begin
              state <= S_EMIT;
            end else begin
              row_cnt <= row_cnt - 1'b1;
              state   <= S_RT_GO;
            end
          end
        end
        S_EMIT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid    <= 1'b1;
            rsp_full     <= (rows_filled >= FILL_W'(ROWS));
            rsp_distance <= (rows_filled >= FILL_W'(ROWS)) ? best : '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: src/hmd_checker.sv
module hmd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [hmd_pkg::DIST_W-1:0] distance,
  input logic                       history_full
);
  import hmd_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp beat dropped while stalled");

  a_not_full_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !history_full |-> distance == '0)
    else $error("nonzero distance before history full");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid after reset");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_valid && req_ready))
    else $error("result one cycle after a req beat");
endmodule

bind history_min_l2_distance_unit hmd_checker u_hmd_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .distance     (rsp.distance),
  .history_full (rsp.history_full)
);
